// ----- sv/binary_min_heap_queue_assert.svh -----
// Assertion helpers for the heap queue.
`ifndef BINARY_MIN_HEAP_QUEUE_ASSERT_SVH
`define BINARY_MIN_HEAP_QUEUE_ASSERT_SVH

// property must hold at every clock edge outside reset
`define BMHQ_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define BMHQ_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ----- sv/bmhq_pkg.sv -----
package bmhq_pkg;

	localparam int unsigned CAPACITY_DEF   = 1024;
	localparam int unsigned KEY_WIDTH_DEF  = 16;
	localparam int unsigned ITEM_WIDTH_DEF = 16;

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// packed so that out_valid lands in bit 0 and status above it
	typedef struct packed {
		status_t status;
		logic    out_valid;
	} res_flags_t;

endpackage

// ----- sv/bmhq_store.sv -----
module bmhq_store
	import bmhq_pkg::*;
#(
	parameter int unsigned DEPTH  = CAPACITY_DEF,
	parameter int unsigned DATA_W = KEY_WIDTH_DEF + ITEM_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DATA_W-1:0]        wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output logic [DATA_W-1:0]        rd_data_a,
	output logic [DATA_W-1:0]        rd_data_b
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_a <= mem_q[rd_addr_a];
		rd_data_b <= mem_q[rd_addr_b];
	end

endmodule

// ----- sv/bmhq_ctrl.sv -----
module bmhq_ctrl
	import bmhq_pkg::*;
#(
	parameter int unsigned CAPACITY   = CAPACITY_DEF,
	parameter int unsigned KEY_WIDTH  = KEY_WIDTH_DEF,
	parameter int unsigned ITEM_WIDTH = ITEM_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  op_t                           in_op,
	input  logic [KEY_WIDTH-1:0]          in_key,
	input  logic [ITEM_WIDTH-1:0]         in_item,
	output logic                          res_valid,
	input  logic                          res_ready,
	output res_flags_t                    res_flags,
	output logic [KEY_WIDTH-1:0]          res_key,
	output logic [ITEM_WIDTH-1:0]         res_item,
	output logic [$clog2(CAPACITY+1)-1:0] res_fill
);

	`include "binary_min_heap_queue_assert.svh"

	localparam int unsigned IDX_W  = $clog2(CAPACITY);
	localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
	localparam int unsigned CW     = IDX_W + 1;
	localparam int unsigned PAIR_W = KEY_WIDTH + ITEM_WIDTH;

	typedef enum logic [2:0] {
		S_IDLE,
		S_POP,
		S_UP_ISSUE,
		S_UP,
		S_DN_ISSUE,
		S_DN,
		S_FIN
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    count_q;
	logic [IDX_W-1:0]    n_q;
	logic [PAIR_W-1:0]   cur_q;
	res_flags_t          flags_q;
	logic [KEY_WIDTH-1:0]  key_q;
	logic [ITEM_WIDTH-1:0] item_q;

	logic                wr_en;
	logic [IDX_W-1:0]    wr_addr;
	logic [PAIR_W-1:0]   wr_data;
	logic [IDX_W-1:0]    rd_addr_a;
	logic [IDX_W-1:0]    rd_addr_b;
	logic [PAIR_W-1:0]   rd_data_a;
	logic [PAIR_W-1:0]   rd_data_b;

	logic [CW-1:0]       cnt_x;
	logic [CW-1:0]       l_x;
	logic [CW-1:0]       r_x;
	logic [IDX_W-1:0]    parent;
	logic [IDX_W-1:0]    last;
	logic                is_full;
	logic                up_swap;
	logic                dn_leaf;
	logic                has_r;
	logic                sel_r;
	logic [PAIR_W-1:0]   child;
	logic [CW-1:0]       child_idx;
	logic                dn_swap;
	logic                accept;
	logic                pop_go;
	logic [CNT_W-1:0]    cnt_m1;

	bmhq_store #(
		.DEPTH  (CAPACITY),
		.DATA_W (PAIR_W)
	) u_store (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b)
	);

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign res_valid = (state_q == S_FIN);
	assign res_flags = flags_q;
	assign res_key   = key_q;
	assign res_item  = item_q;
	assign res_fill  = count_q;

	assign pop_go  = accept && (in_op == OP_POP) && (count_q != '0);
	assign cnt_m1  = count_q - CNT_W'(1);

	assign cnt_x   = CW'(count_q);
	assign l_x     = {n_q, 1'b1};
	assign r_x     = l_x + CW'(1);
	assign parent  = IDX_W'((n_q - IDX_W'(1)) >> 1);
	assign last    = IDX_W'(count_q - CNT_W'(1));
	assign is_full = (count_q == CNT_W'(CAPACITY));

	// pair layout: key in the low bits, handle above
	assign up_swap   = rd_data_a[KEY_WIDTH-1:0] > cur_q[KEY_WIDTH-1:0];
	assign dn_leaf   = (l_x >= cnt_x);
	assign has_r     = (r_x < cnt_x);
	// ties go to the right child
	assign sel_r     = has_r && (rd_data_b[KEY_WIDTH-1:0] <= rd_data_a[KEY_WIDTH-1:0]);
	assign child     = sel_r ? rd_data_b : rd_data_a;
	assign child_idx = sel_r ? r_x : l_x;
	assign dn_swap   = child[KEY_WIDTH-1:0] < cur_q[KEY_WIDTH-1:0];

	always_comb begin
		rd_addr_a = '0;
		rd_addr_b = last;
		wr_en     = 1'b0;
		wr_addr   = n_q;
		wr_data   = cur_q;
		case (state_q)
			S_UP_ISSUE: begin
				rd_addr_a = parent;
				wr_en     = (n_q == '0);
			end
			S_UP: begin
				wr_en = 1'b1;
				if (up_swap) begin
					wr_data = rd_data_a;
				end
			end
			S_DN_ISSUE: begin
				rd_addr_a = l_x[IDX_W-1:0];
				rd_addr_b = r_x[IDX_W-1:0];
				wr_en     = dn_leaf;
			end
			S_DN: begin
				wr_en = 1'b1;
				if (dn_swap) begin
					wr_data = child;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			n_q     <= '0;
			cur_q   <= '0;
			flags_q <= '{status: ST_OK, out_valid: 1'b0};
			key_q   <= '0;
			item_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						key_q   <= '0;
						item_q  <= '0;
						if (in_op == OP_PUSH) begin
							if (is_full) begin
								flags_q <= '{status: ST_FULL, out_valid: 1'b0};
								state_q <= S_FIN;
							end else begin
								flags_q <= '{status: ST_OK, out_valid: 1'b0};
								cur_q   <= {in_item, in_key};
								n_q     <= IDX_W'(count_q);
								count_q <= count_q + CNT_W'(1);
								state_q <= S_UP_ISSUE;
							end
						end else begin
							if (count_q == '0) begin
								flags_q <= '{status: ST_EMPTY, out_valid: 1'b0};
								state_q <= S_FIN;
							end else begin
								flags_q <= '{status: ST_OK, out_valid: 1'b0};
								count_q <= count_q - CNT_W'(1);
								state_q <= S_POP;
							end
						end
					end
				end
				S_POP: begin
					// root goes out, last pair restarts at the root
					flags_q.out_valid <= 1'b1;
					key_q   <= rd_data_a[KEY_WIDTH-1:0];
					item_q  <= rd_data_a[PAIR_W-1:KEY_WIDTH];
					cur_q   <= rd_data_b;
					n_q     <= '0;
					state_q <= (count_q == '0) ? S_FIN : S_DN_ISSUE;
				end
				S_UP_ISSUE: begin
					if (n_q == '0) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_UP;
					end
				end
				S_UP: begin
					if (up_swap) begin
						n_q     <= parent;
						state_q <= S_UP_ISSUE;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_DN_ISSUE: begin
					state_q <= dn_leaf ? S_FIN : S_DN;
				end
				S_DN: begin
					if (dn_swap) begin
						n_q     <= child_idx[IDX_W-1:0];
						state_q <= S_DN_ISSUE;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`BMHQ_NEVER(a_count_range, clk, arst_n, count_q > CNT_W'(CAPACITY), "fill count past capacity")
	`BMHQ_ASSERT(a_wr_in_heap, clk, arst_n, wr_en |-> (CW'(wr_addr) < cnt_x), "write outside heap")
	`BMHQ_ASSERT(a_pop_dec, clk, arst_n, pop_go |=> (count_q == $past(cnt_m1)), "pop miscount")
	`BMHQ_ASSERT(a_busy, clk, arst_n, accept |=> !in_ready, "request taken while idle stays idle")

endmodule

// ----- sv/binary_min_heap_queue.sv -----
// Min-heap priority queue, one request at a time.
// Push: the new pair climbs level by level to the root or until no parent key is larger.
// Pop: the root goes out and the last pair sinks from the root level by level.
// Pop to empty skips the sinking; full push and empty pop only report ST_FULL or ST_EMPTY.
// Result enters the output register as s_axis_tready returns; a second one waiting stalls input.
// Reset clears fill count and control; heap memory is not cleared (slots are written first).
module binary_min_heap_queue
	import bmhq_pkg::*;
#(
	parameter int unsigned CAPACITY   = CAPACITY_DEF,
	parameter int unsigned KEY_WIDTH  = KEY_WIDTH_DEF,
	parameter int unsigned ITEM_WIDTH = ITEM_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// key, item_id
	input  logic [((KEY_WIDTH+ITEM_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	// func
	input  logic s_axis_tuser,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// out_key, out_item_id, fill_count
	output logic [((KEY_WIDTH+ITEM_WIDTH+$clog2(CAPACITY+1)+7)/8)*8-1:0] m_axis_tdata,
	// out_valid, status
	output logic [2:0] m_axis_tuser
);

	localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
	localparam int unsigned OUT_RW = KEY_WIDTH + ITEM_WIDTH + CNT_W;
	localparam int unsigned OUT_DW = ((OUT_RW + 7) / 8) * 8;

	logic                  res_valid;
	logic                  res_ready;
	res_flags_t            res_flags;
	logic [KEY_WIDTH-1:0]  res_key;
	logic [ITEM_WIDTH-1:0] res_item;
	logic [CNT_W-1:0]      res_fill;

	logic                  m_valid_q;
	logic [OUT_RW-1:0]     m_data_q;
	res_flags_t            m_flags_q;

	bmhq_ctrl #(
		.CAPACITY   (CAPACITY),
		.KEY_WIDTH  (KEY_WIDTH),
		.ITEM_WIDTH (ITEM_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_op     (op_t'(s_axis_tuser)),
		.in_key    (s_axis_tdata[KEY_WIDTH-1:0]),
		.in_item   (s_axis_tdata[KEY_WIDTH +: ITEM_WIDTH]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_flags (res_flags),
		.res_key   (res_key),
		.res_item  (res_item),
		.res_fill  (res_fill)
	);

	assign res_ready = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_ready) begin
			m_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_data_q  <= {res_fill, res_item, res_key};
			m_flags_q <= res_flags;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = OUT_DW'(m_data_q);
	assign m_axis_tuser  = m_flags_q;

endmodule
